// ----- hw/rtl/fxalu_pkg.sv -----
`default_nettype none

package fxalu_pkg;

  // operation codes, all sixteen are in use
  typedef enum logic [3:0] {
    FN_ADD      = 4'd0,
    FN_SUB      = 4'd1,
    FN_MUL      = 4'd2,
    FN_DIV      = 4'd3,
    FN_GT       = 4'd4,
    FN_LT       = 4'd5,
    FN_GE       = 4'd6,
    FN_LE       = 4'd7,
    FN_EQ       = 4'd8,
    FN_NE       = 4'd9,
    FN_MIN      = 4'd10,
    FN_MAX      = 4'd11,
    FN_INC      = 4'd12,
    FN_DEC      = 4'd13,
    FN_FROM_INT = 4'd14,
    FN_TO_INT   = 4'd15
  } func_t;

  // command word
  typedef struct packed {
    func_t              func;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
  } cmd_t;

  // response word
  typedef struct packed {
    logic signed [31:0] value_out;
    logic               compare_true;
    logic               divide_by_zero;
  } rsp_t;

  // control flags that ride along the divider row
  typedef struct packed {
    logic valid;
    logic is_div;
    logic neg;
    logic cmp;
    logic dz;
  } ctl_t;

endpackage

`default_nettype wire

// ----- hw/rtl/fxalu_front.sv -----
`default_nettype none

module fxalu_front #(
  parameter int FRAC_BITS = 8,
  parameter int NUM_W     = 32 + FRAC_BITS
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             cmd_valid,
  input  fxalu_pkg::cmd_t  cmd,
  output fxalu_pkg::ctl_t  ctl,
  output logic [31:0]      den,
  output logic [NUM_W-1:0] nq
);
  import fxalu_pkg::*;

  // first stage: simple results and the raw product
  logic               v1;
  func_t              func1;
  logic signed [31:0] a1;
  logic signed [31:0] b1;
  logic signed [63:0] prod1;
  logic signed [31:0] val1;
  logic               cmp1;
  logic signed [31:0] val1_next;
  logic               cmp1_next;

  // second stage inputs
  ctl_t             ctl_next;
  logic [31:0]      den_next;
  logic [NUM_W-1:0] nq_next;
  logic [31:0]      a_mag;
  logic [31:0]      b_mag;

  always_comb begin
    val1_next = '0;
    cmp1_next = 1'b0;
    case (cmd.func)
      FN_ADD:      val1_next = cmd.operand_a + cmd.operand_b;
      FN_SUB:      val1_next = cmd.operand_a - cmd.operand_b;
      FN_GT:       cmp1_next = cmd.operand_a > cmd.operand_b;
      FN_LT:       cmp1_next = cmd.operand_a < cmd.operand_b;
      FN_GE:       cmp1_next = cmd.operand_a >= cmd.operand_b;
      FN_LE:       cmp1_next = cmd.operand_a <= cmd.operand_b;
      FN_EQ:       cmp1_next = cmd.operand_a == cmd.operand_b;
      FN_NE:       cmp1_next = cmd.operand_a != cmd.operand_b;
      FN_MIN:      val1_next = (cmd.operand_a < cmd.operand_b) ? cmd.operand_a : cmd.operand_b;
      FN_MAX:      val1_next = (cmd.operand_a > cmd.operand_b) ? cmd.operand_a : cmd.operand_b;
      FN_INC:      val1_next = cmd.operand_a + 32'sd1;
      FN_DEC:      val1_next = cmd.operand_a - 32'sd1;
      FN_FROM_INT: val1_next = cmd.operand_a <<< FRAC_BITS;
      FN_TO_INT:   val1_next = cmd.operand_a >>> FRAC_BITS;
      default:     val1_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1    <= cmd_valid;
      func1 <= cmd.func;
      a1    <= cmd.operand_a;
      b1    <= cmd.operand_b;
      prod1 <= 64'(cmd.operand_a) * 64'(cmd.operand_b);
      val1  <= val1_next;
      cmp1  <= cmp1_next;
    end
  end

  // magnitudes for the divider row
  assign a_mag = a1[31] ? 32'(-a1) : 32'(a1);
  assign b_mag = b1[31] ? 32'(-b1) : 32'(b1);

  always_comb begin
    ctl_next        = '0;
    ctl_next.valid  = v1;
    ctl_next.cmp    = cmp1;
    den_next        = b_mag;
    nq_next         = '0;
    nq_next[31:0]   = val1;
    case (func1)
      FN_MUL: begin
        nq_next[31:0] = prod1[FRAC_BITS +: 32];
      end
      FN_DIV: begin
        if (b1 == 32'sd0) begin
          ctl_next.dz   = 1'b1;
          nq_next       = '0;
        end else begin
          ctl_next.is_div = 1'b1;
          ctl_next.neg    = a1[31] ^ b1[31];
          nq_next         = NUM_W'({a_mag, {FRAC_BITS{1'b0}}});
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '0;
    end else if (en) begin
      ctl <= ctl_next;
      den <= den_next;
      nq  <= nq_next;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/fxalu_cell.sv -----
`default_nettype none

module fxalu_cell #(
  parameter int NUM_W = 40
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  fxalu_pkg::ctl_t  up_ctl,
  input  logic [31:0]      up_den,
  input  logic [31:0]      up_rem,
  input  logic [NUM_W-1:0] up_nq,
  output fxalu_pkg::ctl_t  ctl,
  output logic [31:0]      den,
  output logic [31:0]      rem,
  output logic [NUM_W-1:0] nq
);
  import fxalu_pkg::*;

  // one restoring step: next numerator bit in, one quotient bit out
  logic [32:0]      trial;
  logic [32:0]      diff;
  logic             qbit;
  logic [31:0]      rem_next;
  logic [NUM_W-1:0] nq_next;

  assign trial = {up_rem, up_nq[NUM_W-1]};
  assign diff  = trial - {1'b0, up_den};
  assign qbit  = ~diff[32];

  always_comb begin
    rem_next = up_rem;
    nq_next  = up_nq;
    if (up_ctl.is_div) begin
      rem_next = qbit ? diff[31:0] : trial[31:0];
      nq_next  = {up_nq[NUM_W-2:0], qbit};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '0;
    end else if (en) begin
      ctl <= up_ctl;
      den <= up_den;
      rem <= rem_next;
      nq  <= nq_next;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/fixed_point_alu_core.sv -----
// signed 32-bit fixed-point alu with FRAC_BITS fraction bits (q24.8 by default)
// command channel: cmd_valid / cmd_stall carry a cmd word (func, operand_a,
//   operand_b); a word is taken at a clock edge with cmd_valid high and
//   cmd_stall low
// response channel: rsp_valid / rsp_stall carry a rsp word (value_out,
//   compare_true, divide_by_zero); exactly one response per command, in order
// throughput: one command per cycle while rsp_stall does not hold the output, every operation alike
// pipeline from the accepting edge to rsp_valid: two front stages, then the
//   divider row with one cell per quotient bit, 32 + FRAC_BITS cells, then the
//   output register
// every operation flows through the same row so order is kept for free
// when the receiver stalls, the output register holds its word and the whole
//   pipeline freezes; cmd_stall then follows rsp_stall combinationally
// reset (rst, synchronous) drops every valid bit in the pipe; no response
//   is pending afterwards and the block takes a command on the next cycle
`default_nettype none

module fixed_point_alu_core #(
  parameter int FRAC_BITS = 8
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cmd_valid,
  output logic            cmd_stall,
  input  fxalu_pkg::cmd_t cmd,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  output fxalu_pkg::rsp_t rsp
);
  import fxalu_pkg::*;

  // numerator width: dividend magnitude shifted up by the fraction
  localparam int NumW = 32 + FRAC_BITS;

  // pipeline moves whenever the output register is free or being drained
  logic adv;
  assign adv       = ~rsp_valid | ~rsp_stall;
  assign cmd_stall = ~adv;

  // divider row taps, index 0 is the front end
  ctl_t            chain_ctl [0:NumW];
  logic [31:0]     chain_den [0:NumW];
  logic [31:0]     chain_rem [0:NumW];
  logic [NumW-1:0] chain_nq  [0:NumW];

  fxalu_front #(
    .FRAC_BITS (FRAC_BITS),
    .NUM_W     (NumW)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .ctl       (chain_ctl[0]),
    .den       (chain_den[0]),
    .nq        (chain_nq[0])
  );

  // partial remainder starts at zero
  assign chain_rem[0] = '0;

  // one cell per quotient bit, msb first
  for (genvar i = 0; i < NumW; i++) begin : g_cell
    fxalu_cell #(
      .NUM_W (NumW)
    ) u_cell (
      .clk    (clk),
      .rst    (rst),
      .en     (adv),
      .up_ctl (chain_ctl[i]),
      .up_den (chain_den[i]),
      .up_rem (chain_rem[i]),
      .up_nq  (chain_nq[i]),
      .ctl    (chain_ctl[i+1]),
      .den    (chain_den[i+1]),
      .rem    (chain_rem[i+1]),
      .nq     (chain_nq[i+1])
    );
  end

  // output register: quotient sign fix, everything else passes
  ctl_t        tail_ctl;
  logic [31:0] tail_val;
  rsp_t        rsp_next;

  assign tail_ctl = chain_ctl[NumW];
  assign tail_val = chain_nq[NumW][31:0];

  always_comb begin
    rsp_next.value_out      = (tail_ctl.is_div && tail_ctl.neg) ? -tail_val : tail_val;
    rsp_next.compare_true   = tail_ctl.cmp;
    rsp_next.divide_by_zero = tail_ctl.dz;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (adv) begin
      rsp_valid <= tail_ctl.valid;
      rsp       <= rsp_next;
    end
  end

  // a zero divisor gives a zero value and no compare outcome
  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.divide_by_zero |-> rsp.value_out == 32'sd0 && !rsp.compare_true)
    else $error("divide by zero response carries data");

  // the row freezes while the output word is held
  a_row_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> $stable(tail_ctl))
    else $error("divider row moved during output stall");

  // nothing is pending right after reset
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid && !tail_ctl.valid)
    else $error("response pending after reset");

endmodule

`default_nettype wire
